/* rtl/rchl_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the hopping receiver link
package rchl_pkg;

    localparam int HOP_CHANNELS = 20;
    localparam int HOP_AW       = $clog2(HOP_CHANNELS);

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;

    // input event codes
    localparam logic [1:0] MODE_POLL   = 2'd0;
    localparam logic [1:0] MODE_PKT    = 2'd1;
    localparam logic [1:0] MODE_UNBIND = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RETUNE = 2'd0;
    localparam logic [1:0] KIND_SERVO  = 2'd1;
    localparam logic [1:0] KIND_STORE  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // link phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_TBL0  = 3'd2;
    localparam logic [2:0] PH_TBL2  = 3'd4;
    localparam logic [2:0] PH_BOUND = 3'd5;
    localparam logic [2:0] PH_RECV  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_TO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIND_CH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIND_ADDR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF = 3'd4;

    localparam logic [19:0] DWELL_RST       = 20'd9500;
    localparam logic [15:0] ONLINE_TO_RST   = 16'd1000;
    localparam logic [6:0]  BIND_CH_RST     = 7'd81;
    localparam logic [39:0] BIND_ADDR_RST   = 40'h1223234578;
    localparam logic [4:0]  MAX_BACKOFF_RST = 5'd21;

    localparam logic [7:0] HDR_B0     = 8'hFF;
    localparam logic [7:0] HDR_B1     = 8'hAA;
    localparam logic [7:0] HDR_B2     = 8'h55;
    localparam logic [7:0] UNBOUND_CH = 8'hFF;
    localparam logic [9:0] SERVO_MAX  = 10'd1000;

    localparam int         TBL_CHUNK     = 7;
    localparam logic [2:0] TBL_FULL_LAST = 3'd6;
    localparam logic [2:0] TBL_TAIL_LAST = 3'd5;

    typedef struct packed {
        logic [19:0] dwell_us;
        logic [15:0] online_to;
        logic [6:0]  bind_ch;
        logic [39:0] bind_addr;
        logic [4:0]  max_backoff;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      now_us;
        logic [9:0][7:0]  pkt;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rf_channel;
        logic [39:0] rf_address;
        logic        flush_fifo;
        logic [2:0]  servo_index;
        logic [9:0]  servo_value;
        logic        online;
        logic        bound;
        logic [2:0]  link_phase;
        logic        last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [HOP_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [HOP_AW-1:0] raddr;
    } t_mem_req;

endpackage

/* rtl/rchl_hop_mem.sv */
`timescale 1ns / 1ps
// hop table memory, one write and one registered read port, unwritten entries read as unbound
module rchl_hop_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rchl_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0]                        r_mem [rchl_pkg::HOP_CHANNELS];
    logic [rchl_pkg::HOP_CHANNELS-1:0] r_vld;
    logic [7:0]                        r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_vld[i_req.raddr] ? r_mem[i_req.raddr] : rchl_pkg::UNBOUND_CH;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rchl_seq.sv */
`timescale 1ns / 1ps
// link sequencer: decides per event, fills the hop table and emits the result words
module rchl_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rchl_pkg::t_cfg     i_cfg,
    input  logic               i_item_vld,
    input  rchl_pkg::t_item    i_item,
    output logic               o_item_take,
    input  logic [7:0]         i_mem_rdata,
    output rchl_pkg::t_mem_req o_mem_req,
    input  logic               i_out_rdy,
    output logic               o_push,
    output rchl_pkg::t_result  o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RETUNE,
        S_SERVO,
        S_FILL,
        S_STORE,
        S_STATUS
    } t_state;

    localparam int AW = rchl_pkg::HOP_AW;

    t_state          r_state, n_state;
    logic [2:0]      r_phase, n_phase;
    logic [AW-1:0]   r_hop_idx, n_hop_idx;
    logic [4:0]      r_step, n_step;
    logic [31:0]     r_deadline, n_deadline;
    logic [15:0]     r_sum, n_sum;
    logic [39:0]     r_link_addr, n_link_addr;
    logic [15:0]     r_online_cnt, n_online_cnt;
    logic            r_bound, n_bound;
    logic            r_flush, n_flush;
    logic            r_use_bind, n_use_bind;
    logic            r_servo_next, n_servo_next;
    logic            r_store_next, n_store_next;
    logic [2:0]      r_cnt, n_cnt;
    logic [2:0]      r_fill_last, n_fill_last;
    logic [AW-1:0]   r_fill_base, n_fill_base;
    logic [9:0][7:0] r_bytes;

    logic            w_hdr_ok;
    logic            w_tbl_ok;
    logic [1:0]      w_part;
    logic [15:0]     w_hdr_sum;
    logic [31:0]     w_late;
    logic            w_passed;
    logic [5:0]      w_step_dbl;
    logic [4:0]      w_step_new;
    logic [AW-1:0]   w_idx_adv;
    logic [AW-1:0]   w_idx_inc;
    logic [24:0]     w_dwell;
    logic [15:0]     w_online_dec;
    logic [3:0]      w_fill_sel;
    logic [AW-1:0]   w_fill_addr;
    logic [15:0]     w_high;
    logic [9:0]      w_servo_raw;
    logic [9:0]      w_servo_val;

    // hop index plus a step of at most 31 folded back into the table range
    function automatic logic [AW-1:0] hop_wrap(input logic [5:0] v);
        logic [5:0] r;
        if (v >= 6'(2 * rchl_pkg::HOP_CHANNELS)) begin
            r = v - 6'(2 * rchl_pkg::HOP_CHANNELS);
        end else if (v >= 6'(rchl_pkg::HOP_CHANNELS)) begin
            r = v - 6'(rchl_pkg::HOP_CHANNELS);
        end else begin
            r = v;
        end
        return r[AW-1:0];
    endfunction

    assign w_hdr_ok = (i_item.pkt[0] == rchl_pkg::HDR_B0) &&
                      (i_item.pkt[1] == rchl_pkg::HDR_B1) &&
                      (i_item.pkt[2] == rchl_pkg::HDR_B2);
    assign w_part   = 2'(r_phase - rchl_pkg::PH_TBL0);
    assign w_tbl_ok = (i_item.pkt[0] == r_sum[7:0]) &&
                      (i_item.pkt[1] == r_sum[15:8]) &&
                      (i_item.pkt[2] == {6'd0, w_part});
    assign w_hdr_sum = r_sum + 16'(i_item.pkt[3]) + 16'(i_item.pkt[4]) +
                       16'(i_item.pkt[5]) + 16'(i_item.pkt[6]) + 16'(i_item.pkt[7]);

    // wrap-aware deadline test
    assign w_late   = i_item.now_us - r_deadline;
    assign w_passed = !w_late[31];

    always_comb begin
        w_step_dbl = {r_step, 1'b0};
        if (w_step_dbl == 6'd0) begin
            w_step_dbl = 6'd1;
        end
        if (w_step_dbl > {1'b0, i_cfg.max_backoff}) begin
            w_step_dbl = {1'b0, i_cfg.max_backoff};
        end
        w_step_new = w_step_dbl[4:0];
    end

    assign w_idx_adv    = hop_wrap(6'(r_hop_idx) + 6'(w_step_new));
    assign w_idx_inc    = hop_wrap(6'(r_hop_idx) + 6'd1);
    assign w_dwell      = 25'(w_step_new) * 25'(i_cfg.dwell_us);
    assign w_online_dec = (r_online_cnt != 16'd0) ? r_online_cnt - 16'd1 : r_online_cnt;

    assign w_fill_sel  = 4'(r_cnt) + 4'd3;
    assign w_fill_addr = r_fill_base + AW'(r_cnt);

    assign w_high      = {r_bytes[9], r_bytes[8]};
    assign w_servo_raw = {w_high[{r_cnt, 1'b0} +: 2], r_bytes[{1'b0, r_cnt}]};
    assign w_servo_val = (w_servo_raw > rchl_pkg::SERVO_MAX) ? rchl_pkg::SERVO_MAX
                                                             : w_servo_raw;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_hop_idx    = r_hop_idx;
        n_step       = r_step;
        n_deadline   = r_deadline;
        n_sum        = r_sum;
        n_link_addr  = r_link_addr;
        n_online_cnt = r_online_cnt;
        n_bound      = r_bound;
        n_flush      = r_flush;
        n_use_bind   = r_use_bind;
        n_servo_next = r_servo_next;
        n_store_next = r_store_next;
        n_cnt        = r_cnt;
        n_fill_last  = r_fill_last;
        n_fill_base  = r_fill_base;
        o_item_take  = 1'b0;
        o_mem_req    = '0;
        o_push       = 1'b0;
        o_res        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_item_vld) begin
                    o_item_take = 1'b1;
                    if (i_item.mode == rchl_pkg::MODE_UNBIND) begin
                        n_phase = rchl_pkg::PH_START;
                        if (r_bound) begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = '0;
                            o_mem_req.wdata = rchl_pkg::UNBOUND_CH;
                            n_bound         = 1'b0;
                            n_state         = S_STORE;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end else if (r_phase == rchl_pkg::PH_START) begin
                        n_use_bind   = 1'b1;
                        n_flush      = 1'b1;
                        n_servo_next = 1'b0;
                        n_sum        = '0;
                        n_phase      = rchl_pkg::PH_HDR;
                        n_state      = S_RETUNE;
                    end else if (r_phase == rchl_pkg::PH_BOUND) begin
                        n_step          = '0;
                        n_hop_idx       = '0;
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = '0;
                        n_deadline      = i_item.now_us + 32'(i_cfg.dwell_us);
                        n_use_bind      = 1'b0;
                        n_flush         = 1'b1;
                        n_servo_next    = 1'b0;
                        n_phase         = rchl_pkg::PH_RECV;
                        n_state         = S_RETUNE;
                    end else begin
                        n_online_cnt = w_online_dec;
                        n_state      = S_STATUS;
                        if (i_item.mode != rchl_pkg::MODE_PKT) begin
                            if (r_phase == rchl_pkg::PH_RECV && w_passed) begin
                                // missed packet: back off the hop step
                                n_step          = w_step_new;
                                n_hop_idx       = w_idx_adv;
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = w_idx_adv;
                                n_deadline      = i_item.now_us + 32'(w_dwell);
                                n_use_bind      = 1'b0;
                                n_flush         = 1'b0;
                                n_servo_next    = 1'b0;
                                n_state         = S_RETUNE;
                            end
                        end else if (r_phase == rchl_pkg::PH_HDR) begin
                            if (w_hdr_ok) begin
                                n_link_addr = {i_item.pkt[3], i_item.pkt[4], i_item.pkt[5],
                                               i_item.pkt[6], i_item.pkt[7]};
                                n_sum       = w_hdr_sum;
                                n_phase     = rchl_pkg::PH_TBL0;
                            end
                        end else if (r_phase >= rchl_pkg::PH_TBL0 &&
                                     r_phase <= rchl_pkg::PH_TBL2) begin
                            if (w_tbl_ok) begin
                                n_cnt        = '0;
                                n_fill_base  = AW'(w_part * rchl_pkg::TBL_CHUNK);
                                n_store_next = (r_phase == rchl_pkg::PH_TBL2);
                                n_fill_last  = (r_phase == rchl_pkg::PH_TBL2)
                                               ? rchl_pkg::TBL_TAIL_LAST
                                               : rchl_pkg::TBL_FULL_LAST;
                                n_phase      = r_phase + 3'd1;
                                n_state      = S_FILL;
                            end
                        end else begin
                            // data packet
                            n_step          = '0;
                            n_hop_idx       = w_idx_inc;
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = w_idx_inc;
                            n_deadline      = i_item.now_us + 32'(i_cfg.dwell_us);
                            n_online_cnt    = i_cfg.online_to;
                            n_use_bind      = 1'b0;
                            n_flush         = 1'b0;
                            n_servo_next    = 1'b1;
                            n_cnt           = '0;
                            n_state         = S_RETUNE;
                        end
                    end
                end
            end
            S_RETUNE: begin
                o_res.kind       = rchl_pkg::KIND_RETUNE;
                o_res.rf_channel = r_use_bind ? {1'b0, i_cfg.bind_ch} : i_mem_rdata;
                o_res.rf_address = r_use_bind ? i_cfg.bind_addr : r_link_addr;
                o_res.flush_fifo = r_flush;
                if (i_out_rdy) begin
                    o_push  = 1'b1;
                    n_state = r_servo_next ? S_SERVO : S_STATUS;
                end
            end
            S_SERVO: begin
                o_res.kind        = rchl_pkg::KIND_SERVO;
                o_res.servo_index = r_cnt;
                o_res.servo_value = w_servo_val;
                if (i_out_rdy) begin
                    o_push = 1'b1;
                    n_cnt  = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_state = S_STATUS;
                    end
                end
            end
            S_FILL: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = w_fill_addr;
                o_mem_req.wdata = r_bytes[w_fill_sel];
                if (w_fill_addr == '0) begin
                    n_bound = (r_bytes[w_fill_sel] != rchl_pkg::UNBOUND_CH);
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == r_fill_last) begin
                    n_state = r_store_next ? S_STORE : S_STATUS;
                end
            end
            S_STORE: begin
                o_res.kind = rchl_pkg::KIND_STORE;
                if (i_out_rdy) begin
                    o_push  = 1'b1;
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                o_res.kind       = rchl_pkg::KIND_STATUS;
                o_res.online     = (r_online_cnt != 16'd0);
                o_res.bound      = r_bound;
                o_res.link_phase = r_phase;
                o_res.last       = 1'b1;
                if (i_out_rdy) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= rchl_pkg::PH_START;
            r_hop_idx    <= '0;
            r_step       <= '0;
            r_deadline   <= '0;
            r_sum        <= '0;
            r_link_addr  <= '0;
            r_online_cnt <= '0;
            r_bound      <= 1'b0;
            r_flush      <= 1'b0;
            r_use_bind   <= 1'b0;
            r_servo_next <= 1'b0;
            r_store_next <= 1'b0;
            r_cnt        <= '0;
            r_fill_last  <= '0;
            r_fill_base  <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_hop_idx    <= n_hop_idx;
            r_step       <= n_step;
            r_deadline   <= n_deadline;
            r_sum        <= n_sum;
            r_link_addr  <= n_link_addr;
            r_online_cnt <= n_online_cnt;
            r_bound      <= n_bound;
            r_flush      <= n_flush;
            r_use_bind   <= n_use_bind;
            r_servo_next <= n_servo_next;
            r_store_next <= n_store_next;
            r_cnt        <= n_cnt;
            r_fill_last  <= n_fill_last;
            r_fill_base  <= n_fill_base;
        end
    end

    // packet bytes kept for the fill and servo steps
    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_bytes <= i_item.pkt;
        end
    end

endmodule

/* rtl/rc_hopping_receiver_link.sv */
`timescale 1ns / 1ps
// hopping receiver link top level: config registers, input buffer, output word register
// an event word goes through the input buffer, the sequencer state and the output word register
// per event a decide step, then the result words, and a bind table packet also makes seven
// table writes (the last packet six); a data packet yields 10 result words
// the input buffer takes the next event word while the sequencer and output register still work
// sync active-low reset: unbound at phase zero, config defaults, per-entry valid flags, no clearing
module rc_hopping_receiver_link (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rchl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rchl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_us, pkt_b0, pkt_b1, ... pkt_b9
    input  logic [rchl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // mode
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // rf_channel, rf_address, flush_fifo, servo_index, servo_value, online, bound, link_phase
    output logic [rchl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    rchl_pkg::t_cfg     r_cfg;
    rchl_pkg::t_item    r_buf;
    rchl_pkg::t_item    w_in_item;
    logic               r_buf_vld;
    logic               w_take;
    rchl_pkg::t_mem_req w_mem_req;
    logic [7:0]         w_mem_rdata;
    logic               w_out_rdy;
    logic               w_push;
    rchl_pkg::t_result  w_res;
    rchl_pkg::t_result  r_out;
    logic               r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dwell_us    <= rchl_pkg::DWELL_RST;
            r_cfg.online_to   <= rchl_pkg::ONLINE_TO_RST;
            r_cfg.bind_ch     <= rchl_pkg::BIND_CH_RST;
            r_cfg.bind_addr   <= rchl_pkg::BIND_ADDR_RST;
            r_cfg.max_backoff <= rchl_pkg::MAX_BACKOFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rchl_pkg::CFG_DWELL:       r_cfg.dwell_us    <= i_cfg_data[19:0];
                rchl_pkg::CFG_ONLINE_TO:   r_cfg.online_to   <= i_cfg_data[15:0];
                rchl_pkg::CFG_BIND_CH:     r_cfg.bind_ch     <= i_cfg_data[6:0];
                rchl_pkg::CFG_BIND_ADDR:   r_cfg.bind_addr   <= i_cfg_data[39:0];
                rchl_pkg::CFG_MAX_BACKOFF: r_cfg.max_backoff <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_in_item.mode   = s_axis_tuser;
        w_in_item.now_us = s_axis_tdata[31:0];
        for (int k = 0; k < 10; k++) begin
            w_in_item.pkt[k] = s_axis_tdata[32 + 8 * k +: 8];
        end
    end

    // one-word input buffer, refilled in the cycle the sequencer drains it
    assign s_axis_tready = !r_buf_vld || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_buf_vld <= 1'b1;
        end else if (w_take) begin
            r_buf_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_buf <= w_in_item;
        end
    end

    rchl_hop_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    rchl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item_vld  (r_buf_vld),
        .i_item      (r_buf),
        .o_item_take (w_take),
        .i_mem_rdata (w_mem_rdata),
        .o_mem_req   (w_mem_req),
        .i_out_rdy   (w_out_rdy),
        .o_push      (w_push),
        .o_res       (w_res)
    );

    assign w_out_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {5'd0, r_out.link_phase, r_out.bound, r_out.online,
                            r_out.servo_value, r_out.servo_index, r_out.flush_fifo,
                            r_out.rf_address, r_out.rf_channel};

`ifndef NO_ASSERTIONS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.last == (r_out.kind == rchl_pkg::KIND_STATUS)))
        else $error("last word is not the status word");

    a_servo_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == rchl_pkg::KIND_SERVO) |->
            (r_out.servo_value <= rchl_pkg::SERVO_MAX))
        else $error("servo value above saturation limit");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_vld || m_axis_tready))
        else $error("sequencer overwrote a pending output word");

    a_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_buf_vld)
        else $error("sequencer took an event from an empty buffer");
`endif

endmodule

/* verif/rchl_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the hopping receiver link: mirrors the link state and checks every result word
module rchl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rchl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rchl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    // now_us, pkt_b0 .. pkt_b9
    input  logic [rchl_pkg::IN_TDATA_W-1:0]   i_in_data,
    // mode
    input  logic [1:0]                        i_in_mode,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    // rf_channel, rf_address, flush_fifo, servo_index, servo_value, online, bound, link_phase
    input  logic [rchl_pkg::OUT_TDATA_W-1:0]  i_out_data,
    // kind
    input  logic [1:0]                        i_out_kind,
    input  logic                              i_out_last,
    output int                                o_fail_count,
    output int                                o_pending
);

    rchl_pkg::t_cfg    cfg;
    logic [2:0]        phase;
    logic [4:0]        hop_idx;
    logic [4:0]        step;
    logic [31:0]       deadline;
    logic [15:0]       addr_sum;
    logic [15:0]       online_cnt;
    logic [39:0]       link_addr;
    logic [7:0]        hop_tbl [rchl_pkg::HOP_CHANNELS];
    rchl_pkg::t_result due_words [$];
    int                mismatches;

    task automatic clear_link();
        cfg.dwell_us    = rchl_pkg::DWELL_RST;
        cfg.online_to   = rchl_pkg::ONLINE_TO_RST;
        cfg.bind_ch     = rchl_pkg::BIND_CH_RST;
        cfg.bind_addr   = rchl_pkg::BIND_ADDR_RST;
        cfg.max_backoff = rchl_pkg::MAX_BACKOFF_RST;
        phase      = rchl_pkg::PH_START;
        hop_idx    = '0;
        step       = '0;
        deadline   = '0;
        addr_sum   = '0;
        online_cnt = '0;
        link_addr  = '0;
        foreach (hop_tbl[i]) hop_tbl[i] = rchl_pkg::UNBOUND_CH;
        due_words.delete();
        mismatches = 0;
    endtask

    task automatic apply_cfg(input logic [rchl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rchl_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            rchl_pkg::CFG_DWELL:       cfg.dwell_us    = val[19:0];
            rchl_pkg::CFG_ONLINE_TO:   cfg.online_to   = val[15:0];
            rchl_pkg::CFG_BIND_CH:     cfg.bind_ch     = val[6:0];
            rchl_pkg::CFG_BIND_ADDR:   cfg.bind_addr   = val[39:0];
            rchl_pkg::CFG_MAX_BACKOFF: cfg.max_backoff = val[4:0];
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [1:0] kind, input logic [7:0] ch, input logic [39:0] addr,
                             input logic flush, input logic [2:0] idx, input logic [9:0] val);
        rchl_pkg::t_result r;
        r = '0;
        r.kind        = kind;
        r.rf_channel  = ch;
        r.rf_address  = addr;
        r.flush_fifo  = flush;
        r.servo_index = idx;
        r.servo_value = val;
        due_words.push_back(r);
    endtask

    // one event in, its result words queued in order
    task automatic advance_link(input logic [1:0] mode, input logic [31:0] now,
                                input logic [9:0][7:0] pkt);
        logic [31:0]       span;
        logic [15:0]       sum;
        logic [15:0]       high;
        logic [9:0]        raw;
        rchl_pkg::t_result status;
        int                s;
        int                part;
        int                cnt;
        int                e;
        int                i;
        if (mode == rchl_pkg::MODE_UNBIND) begin
            if (hop_tbl[0] != rchl_pkg::UNBOUND_CH) begin
                hop_tbl[0] = rchl_pkg::UNBOUND_CH;
                push_word(rchl_pkg::KIND_STORE, '0, '0, 1'b0, '0, '0);
            end
            phase = rchl_pkg::PH_START;
        end else if (phase == rchl_pkg::PH_START) begin
            push_word(rchl_pkg::KIND_RETUNE, {1'b0, cfg.bind_ch}, cfg.bind_addr, 1'b1, '0, '0);
            addr_sum = '0;
            phase    = rchl_pkg::PH_HDR;
        end else if (phase == rchl_pkg::PH_BOUND) begin
            step    = '0;
            hop_idx = '0;
            push_word(rchl_pkg::KIND_RETUNE, hop_tbl[0], link_addr, 1'b1, '0, '0);
            deadline = now + 32'(cfg.dwell_us);
            phase    = rchl_pkg::PH_RECV;
        end else begin
            if (online_cnt != 0) online_cnt = online_cnt - 16'd1;
            if (mode != rchl_pkg::MODE_PKT) begin
                span = now - deadline;
                // wrap-aware: passed when the distance is in the lower half
                if (phase == rchl_pkg::PH_RECV && span < 32'h8000_0000) begin
                    s = 2 * int'(step);
                    if (s < 1) s = 1;
                    if (s > int'(cfg.max_backoff)) s = int'(cfg.max_backoff);
                    step    = 5'(s);
                    hop_idx = 5'((int'(hop_idx) + s) % rchl_pkg::HOP_CHANNELS);
                    push_word(rchl_pkg::KIND_RETUNE, hop_tbl[hop_idx], link_addr, 1'b0, '0, '0);
                    deadline = now + 32'(s * int'(cfg.dwell_us));
                end
            end else if (phase == rchl_pkg::PH_HDR) begin
                if (pkt[0] == rchl_pkg::HDR_B0 && pkt[1] == rchl_pkg::HDR_B1 &&
                    pkt[2] == rchl_pkg::HDR_B2) begin
                    sum = addr_sum;
                    for (i = 3; i < 8; i++) sum = sum + 16'(pkt[i]);
                    link_addr = {pkt[3], pkt[4], pkt[5], pkt[6], pkt[7]};
                    addr_sum  = sum;
                    phase     = rchl_pkg::PH_TBL0;
                end
            end else if (phase <= rchl_pkg::PH_TBL2) begin
                part = int'(phase) - int'(rchl_pkg::PH_TBL0);
                if (pkt[0] == addr_sum[7:0] && pkt[1] == addr_sum[15:8] && pkt[2] == 8'(part)) begin
                    cnt = (phase != rchl_pkg::PH_TBL2) ? rchl_pkg::TBL_CHUNK
                                                       : rchl_pkg::TBL_CHUNK - 1;
                    for (i = 0; i < cnt; i++) begin
                        e = rchl_pkg::TBL_CHUNK * part + i;
                        if (e < rchl_pkg::HOP_CHANNELS) hop_tbl[e] = pkt[3 + i];
                    end
                    if (phase == rchl_pkg::PH_TBL2) begin
                        push_word(rchl_pkg::KIND_STORE, '0, '0, 1'b0, '0, '0);
                    end
                    phase = phase + 3'd1;
                end
            end else begin
                high    = {pkt[9], pkt[8]};
                step    = '0;
                hop_idx = 5'((int'(hop_idx) + 1) % rchl_pkg::HOP_CHANNELS);
                push_word(rchl_pkg::KIND_RETUNE, hop_tbl[hop_idx], link_addr, 1'b0, '0, '0);
                deadline = now + 32'(cfg.dwell_us);
                for (i = 0; i < 8; i++) begin
                    raw = {high[2*i +: 2], pkt[i]};
                    if (raw > rchl_pkg::SERVO_MAX) raw = rchl_pkg::SERVO_MAX;
                    push_word(rchl_pkg::KIND_SERVO, '0, '0, 1'b0, 3'(i), raw);
                end
                online_cnt = cfg.online_to;
            end
        end
        status            = '0;
        status.kind       = rchl_pkg::KIND_STATUS;
        status.online     = (online_cnt != 0);
        status.bound      = (hop_tbl[0] != rchl_pkg::UNBOUND_CH);
        status.link_phase = phase;
        status.last       = 1'b1;
        due_words.push_back(status);
    endtask

    function automatic string show_word(input rchl_pkg::t_result r);
        return $sformatf({"kind=%0d ch=%0d addr=%h flush=%0d idx=%0d val=%0d ",
                          "online=%0d bound=%0d phase=%0d last=%0d"},
                         r.kind, r.rf_channel, r.rf_address, r.flush_fifo, r.servo_index,
                         r.servo_value, r.online, r.bound, r.link_phase, r.last);
    endfunction

    task automatic check_word();
        rchl_pkg::t_result got;
        rchl_pkg::t_result want;
        got.kind        = i_out_kind;
        got.rf_channel  = i_out_data[7:0];
        got.rf_address  = i_out_data[47:8];
        got.flush_fifo  = i_out_data[48];
        got.servo_index = i_out_data[51:49];
        got.servo_value = i_out_data[61:52];
        got.online      = i_out_data[62];
        got.bound       = i_out_data[63];
        got.link_phase  = i_out_data[66:64];
        got.last        = i_out_last;
        if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %s", show_word(got));
        end else begin
            want = due_words.pop_front();
            if (got !== want || i_out_data[rchl_pkg::OUT_TDATA_W-1:67] !== '0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word mismatch");
                    $display("  expected %s", show_word(want));
                    $display("  actual   %s pad=%h", show_word(got),
                             i_out_data[rchl_pkg::OUT_TDATA_W-1:67]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_link();
        end else begin
            // results always trail their event
            if (i_out_valid && i_out_ready) check_word();
            if (i_cfg_we) apply_cfg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && i_in_ready) advance_link(i_in_mode, i_in_data[31:0], i_in_data[111:32]);
        end
        o_fail_count <= mismatches;
        o_pending    <= due_words.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench top for the hopping receiver link: clock, reset, event traffic and verdict
module tb;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [rchl_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [rchl_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rchl_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rchl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             m_axis_tlast;

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          accepted_items;
    bit          link_ready;
    logic [31:0] clock_us;

    always #4 i_clk = ~i_clk;

    rc_hopping_receiver_link uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rchl_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_kind   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [9:0][7:0] random_pkt();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[79:0];
    endfunction

    function automatic logic [9:0][7:0] table_pkt(input logic [15:0] sum, input int part);
        logic [9:0][7:0] p;
        p    = random_pkt();
        p[0] = sum[7:0];
        p[1] = sum[15:8];
        p[2] = 8'(part);
        return p;
    endfunction

    // offer one event and hold it until the block takes the word
    task automatic send_event(input logic [1:0] mode, input logic [9:0][7:0] pkt);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {pkt, clock_us};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accepted_items++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic quiesce(input int tail_cycles);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (tail_cycles) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [19:0] period, input logic [15:0] timeout,
                                 input logic [6:0] ch, input logic [39:0] addr,
                                 input logic [4:0] backoff);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rchl_pkg::CFG_DWELL;
        i_cfg_data <= 40'(period);
        @(posedge i_clk);
        i_cfg_idx  <= rchl_pkg::CFG_ONLINE_TO;
        i_cfg_data <= 40'(timeout);
        @(posedge i_clk);
        i_cfg_idx  <= rchl_pkg::CFG_BIND_CH;
        i_cfg_data <= 40'(ch);
        @(posedge i_clk);
        i_cfg_idx  <= rchl_pkg::CFG_BIND_ADDR;
        i_cfg_data <= addr;
        @(posedge i_clk);
        i_cfg_idx  <= rchl_pkg::CFG_MAX_BACKOFF;
        i_cfg_data <= 40'(backoff);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        link_ready = 1'b0;
    endtask

    // unbind, bind retune, header, three table packets, first hop; some get a flipped bit
    task automatic run_binding(input int corrupt_pct);
        logic [9:0][7:0] pkt;
        logic [15:0]     sum;
        bit              broken;
        int              part;
        int              pos;
        int              i;
        broken = 1'b0;
        send_event(rchl_pkg::MODE_UNBIND, random_pkt());
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        pkt    = random_pkt();
        pkt[0] = rchl_pkg::HDR_B0;
        pkt[1] = rchl_pkg::HDR_B1;
        pkt[2] = rchl_pkg::HDR_B2;
        sum    = '0;
        for (i = 3; i < 8; i++) sum = sum + 16'(pkt[i]);
        if ($urandom_range(99) < corrupt_pct) begin
            pos      = $urandom_range(2);
            pkt[pos] = pkt[pos] ^ 8'(1 << $urandom_range(7));
            broken   = 1'b1;
        end
        send_event(rchl_pkg::MODE_PKT, pkt);
        for (part = 0; part < 3; part++) begin
            pkt = table_pkt(sum, part);
            if (part == 0 && $urandom_range(19) == 0) pkt[3] = rchl_pkg::UNBOUND_CH;
            if ($urandom_range(99) < corrupt_pct) begin
                pos      = $urandom_range(2);
                pkt[pos] = pkt[pos] ^ 8'(1 << $urandom_range(7));
                broken   = 1'b1;
            end
            clock_us = clock_us + $urandom_range(100, 3000);
            send_event(rchl_pkg::MODE_PKT, pkt);
        end
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        link_ready = !broken;
    endtask

    task automatic random_traffic(input int count);
        logic [9:0][7:0] pkt;
        logic [1:0]      mode;
        int              done;
        int              pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (!link_ready || pick < 4) begin
                run_binding(15);
                done += 7;
            end else if (pick < 55) begin
                clock_us = clock_us + $urandom_range(200, 12000);
                pkt      = random_pkt();
                // high bits all set pushes servo values with a low byte above 232 past the limit
                if ($urandom_range(3) == 0) begin
                    pkt[8] = 8'hFF;
                    pkt[9] = 8'hFF;
                end
                send_event(rchl_pkg::MODE_PKT, pkt);
                done++;
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0: clock_us = clock_us + $urandom_range(0, 3000);
                    1: clock_us = clock_us + $urandom_range(5000, 60000);
                    2: clock_us = clock_us + $urandom_range(0, 32'h0400_0000);
                    default: clock_us = $urandom();
                endcase
                send_event(($urandom_range(4) == 0) ? MODE_SPARE : rchl_pkg::MODE_POLL,
                           random_pkt());
                done++;
            end else if (pick < 96) begin
                mode     = 2'($urandom_range(3));
                clock_us = $urandom();
                send_event(mode, random_pkt());
                if (mode == rchl_pkg::MODE_UNBIND) link_ready = 1'b0;
                done++;
            end else begin
                send_event(rchl_pkg::MODE_UNBIND, random_pkt());
                link_ready = 1'b0;
                done++;
            end
        end
    endtask

    // receiver side: random stalls plus one long hold-off to back the block up
    initial begin
        int hold;
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && accepted_items >= 90) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [9:0][7:0] pkt;
        int              i;
        tx_idle_pct    = 12;
        rx_idle_pct    = 59;
        accepted_items = 0;
        link_ready     = 1'b0;
        clock_us       = 32'd1000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a packet before binding only starts the bind retune
        send_event(rchl_pkg::MODE_PKT, random_pkt());
        pkt    = random_pkt();
        pkt[0] = rchl_pkg::HDR_B0;
        pkt[1] = rchl_pkg::HDR_B1;
        pkt[2] = rchl_pkg::HDR_B2 ^ 8'h01;
        send_event(rchl_pkg::MODE_PKT, pkt);
        send_event(MODE_SPARE, random_pkt());
        // unbind while nothing is stored: no store word
        send_event(rchl_pkg::MODE_UNBIND, random_pkt());
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        pkt = {8'h00, 8'h00, 8'h7F, 8'h01, 8'h80, 8'hFF, 8'h00,
               rchl_pkg::HDR_B2, rchl_pkg::HDR_B1, rchl_pkg::HDR_B0};
        send_event(rchl_pkg::MODE_PKT, pkt);
        // table part out of order is dropped
        send_event(rchl_pkg::MODE_PKT, table_pkt(16'h01FF, 1));
        pkt    = table_pkt(16'h01FF, 0);
        pkt[3] = 8'h00;
        send_event(rchl_pkg::MODE_PKT, pkt);
        send_event(rchl_pkg::MODE_PKT, table_pkt(16'h01FF, 1));
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        send_event(rchl_pkg::MODE_PKT, table_pkt(16'h01FF, 2));
        // packet while bound only starts hopping
        send_event(rchl_pkg::MODE_PKT, random_pkt());
        clock_us = clock_us + 2000;
        send_event(rchl_pkg::MODE_PKT, {10{8'hFF}});
        clock_us = clock_us + 2000;
        send_event(rchl_pkg::MODE_PKT, {8'hFF, 8'hFF, {4{8'hE9, 8'hE8}}});
        clock_us = clock_us + 2000;
        send_event(rchl_pkg::MODE_PKT, {10{8'h00}});
        // deadline exactly half the time range away: not yet passed, one less: passed
        clock_us = clock_us + 32'(rchl_pkg::DWELL_RST) + 32'h8000_0000;
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        clock_us = clock_us - 32'd1;
        send_event(rchl_pkg::MODE_POLL, random_pkt());
        // missed hops double the step up to the cap
        for (i = 0; i < 5; i++) begin
            clock_us = clock_us + 32'd400000;
            send_event(rchl_pkg::MODE_POLL, random_pkt());
        end
        send_event(rchl_pkg::MODE_UNBIND, random_pkt());
        send_event(rchl_pkg::MODE_UNBIND, random_pkt());
        random_traffic(32);

        quiesce(12);
        load_settings(20'd1, 16'd1, 7'd0, 40'd0, 5'd1);
        random_traffic(32);

        quiesce(12);
        tx_idle_pct = 59;
        rx_idle_pct = 12;
        load_settings(20'hFFFFF, 16'hFFFF, 7'h7F, 40'hFF_FFFF_FFFF, 5'd31);
        random_traffic(32);

        quiesce(12);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_settings(20'd0, 16'd0, 7'd125, {8'($urandom()), $urandom()}, 5'd0);
        random_traffic(32);

        quiesce(20);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rchl_pkg.sv
rtl/rchl_hop_mem.sv
rtl/rchl_seq.sv
rtl/rc_hopping_receiver_link.sv
verif/rchl_checker.sv
verif/tb.sv
